// ----- hdl/skf_pkg.sv -----
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types and constants for the scalar Kalman filter core.
// ----------------------------------------------------------------------------
package skf_pkg;

    // Variance / noise format: unsigned Q8.24
    localparam int VAR_W     = 32;
    localparam int FRAC_BITS = 24;
    localparam int GAIN_W    = FRAC_BITS + 1;          // gain in [0, 1.0]
    localparam int DEN_W     = VAR_W + 1;              // P + R held exactly
    localparam int REM_W     = VAR_W + 2;              // divider partial remainder
    localparam int MUL_A_W   = GAIN_W;
    localparam int MUL_B_W   = VAR_W;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int DIV_STEPS = GAIN_W;                 // one quotient bit per cycle
    localparam int DIV_CNT_W = 5;

    localparam logic [GAIN_W-1:0]  ONE_Q24  = GAIN_W'(1) << FRAC_BITS;
    localparam logic [MUL_P_W-1:0] HALF_Q24 = MUL_P_W'(1) << (FRAC_BITS - 1);

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;

    localparam logic [VAR_W-1:0] RESET_PROCESS_NOISE     = 32'd1510;
    localparam logic [VAR_W-1:0] RESET_MEASUREMENT_NOISE = 32'd16777216;
    localparam logic [VAR_W-1:0] RESET_VARIANCE          = 32'd16777216;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;       // capture the input sample
        logic den;        // predicted variance, denominator, innovation
        logic div_step;   // one restoring divider step
        logic mul_var;    // multiply (1 - K) * Pp
        logic mul_lo;     // round variance, multiply K * low innovation bits
        logic mul_hi;     // round low correction, multiply K * high bits
        logic upd;        // apply correction to the estimate
        logic out_load;   // move results into the output register
    } skf_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic out_free;   // output register can take a new beat
    } skf_status_t;

endpackage

// ----- hdl/skf_if.sv -----
// ----------------------------------------------------------------------------
// skf_if
// Valid/ready stream interfaces for samples in and filter results out.
// ----------------------------------------------------------------------------
interface skf_in_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] measurement;

    modport source (output valid, output measurement, input ready);
    modport sink   (input valid, input measurement, output ready);
endinterface

interface skf_out_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] estimate;
    logic [31:0]         error_variance;

    modport source (output valid, output estimate, output error_variance, input ready);
    modport sink   (input valid, input estimate, input error_variance, output ready);
endinterface

// ----- hdl/skf_ctrl.sv -----
// ----------------------------------------------------------------------------
// skf_ctrl
// Sequencer for one filter update: predict, divide, multiply, update, emit.
// ----------------------------------------------------------------------------
module skf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  skf_pkg::skf_status_t status,
    output skf_pkg::skf_cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DEN  = 8'b0000_0010,
        ST_DIV  = 8'b0000_0100,
        ST_MVAR = 8'b0000_1000,
        ST_MLO  = 8'b0001_0000,
        ST_MHI  = 8'b0010_0000,
        ST_UPD  = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    state_t                          state_reg, state_next;
    logic [skf_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DEN;
                end
            end
            ST_DEN:
            begin
                cmd.den    = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == skf_pkg::DIV_CNT_W'(skf_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_MVAR;
                end
            end
            ST_MVAR:
            begin
                cmd.mul_var = 1'b1;
                state_next  = ST_MLO;
            end
            ST_MLO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MHI;
            end
            ST_MHI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- hdl/skf_datapath.sv -----
// ----------------------------------------------------------------------------
// skf_datapath
// Filter state, noise registers, radix-2 gain divider, shared multiplier
// and output register.
// ----------------------------------------------------------------------------
module skf_datapath #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [skf_pkg::VAR_W-1:0]            cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0]       in_measurement,
    input  skf_pkg::skf_cmd_t                    cmd,
    output skf_pkg::skf_status_t                 status,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]       out_estimate,
    output logic [skf_pkg::VAR_W-1:0]            out_error_variance
);

    localparam int MAG_W  = SAMPLE_WIDTH + 1;     // exact innovation magnitude
    localparam int WIDE_W = skf_pkg::FRAC_BITS + skf_pkg::MUL_B_W;

    // Configuration and filter state
    logic [skf_pkg::VAR_W-1:0]          q_reg, r_reg;
    logic signed [SAMPLE_WIDTH-1:0]     est_reg, est_next;
    logic [skf_pkg::VAR_W-1:0]          var_reg;

    // Working registers
    logic signed [SAMPLE_WIDTH-1:0]     z_reg;
    logic [skf_pkg::VAR_W-1:0]          pp_reg;
    logic [skf_pkg::DEN_W-1:0]          den_reg;
    logic                               den_zero_reg;
    logic [skf_pkg::REM_W-1:0]          rem_reg;
    logic [skf_pkg::GAIN_W-1:0]         k_reg;
    logic                               neg_reg;
    logic [MAG_W-1:0]                   mag_reg;
    logic [skf_pkg::MUL_P_W-1:0]        mul_reg;
    logic [skf_pkg::GAIN_W-1:0]         lo_reg;

    // Output register
    logic                               out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0]     out_est_reg;
    logic [skf_pkg::VAR_W-1:0]          out_var_reg;

    // Combinational terms
    logic [skf_pkg::VAR_W:0]            pp_sum;
    logic [skf_pkg::VAR_W-1:0]          pp_sat;
    logic signed [MAG_W-1:0]            z_ext, est_ext, d_fwd, d_rev;
    logic                               div_ge;
    logic [skf_pkg::REM_W-1:0]          div_diff;
    logic [WIDE_W-1:0]                  mag_wide;
    logic [skf_pkg::MUL_A_W-1:0]        mul_a;
    logic [skf_pkg::MUL_B_W-1:0]        mul_b;
    logic [skf_pkg::MUL_P_W-1:0]        rounded;
    logic [MAG_W-1:0]                   corr;
    logic [MAG_W-1:0]                   est_upd;

    // Predicted variance with saturation
    assign pp_sum = {1'b0, var_reg} + {1'b0, q_reg};
    assign pp_sat = pp_sum[skf_pkg::VAR_W] ? '1 : pp_sum[skf_pkg::VAR_W-1:0];

    // Innovation, both directions so the magnitude needs no negate
    assign z_ext   = MAG_W'(z_reg);
    assign est_ext = MAG_W'(est_reg);
    assign d_fwd   = z_ext - est_ext;
    assign d_rev   = est_ext - z_ext;

    // Restoring divider step
    assign div_ge   = (rem_reg >= skf_pkg::REM_W'(den_reg));
    assign div_diff = div_ge ? (rem_reg - skf_pkg::REM_W'(den_reg)) : rem_reg;

    // Shared multiplier operand select
    assign mag_wide = WIDE_W'(mag_reg);
    always_comb
    begin
        mul_a = k_reg;
        mul_b = skf_pkg::MUL_B_W'(mag_wide[skf_pkg::FRAC_BITS-1:0]);
        if (cmd.mul_var)
        begin
            mul_a = skf_pkg::ONE_Q24 - k_reg;
            mul_b = pp_reg;
        end
        else if (cmd.mul_hi)
        begin
            mul_b = mag_wide[WIDE_W-1:skf_pkg::FRAC_BITS];
        end
    end

    // Round-to-nearest of the last product
    assign rounded = mul_reg + skf_pkg::HALF_Q24;

    // Correction and new estimate
    assign corr    = MAG_W'(mul_reg) + MAG_W'(lo_reg);
    assign est_upd = neg_reg ? (MAG_W'(est_reg) - corr) : (MAG_W'(est_reg) + corr);
    assign est_next = est_upd[SAMPLE_WIDTH-1:0];

    // Configuration and filter state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg   <= skf_pkg::RESET_PROCESS_NOISE;
            r_reg   <= skf_pkg::RESET_MEASUREMENT_NOISE;
            est_reg <= '0;
            var_reg <= skf_pkg::RESET_VARIANCE;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    skf_pkg::CFG_PROCESS_NOISE:     q_reg <= cfg_data;
                    skf_pkg::CFG_MEASUREMENT_NOISE: r_reg <= cfg_data;
                    default:                        ;
                endcase
            end
            if (cmd.mul_lo)
            begin
                var_reg <= rounded[skf_pkg::FRAC_BITS +: skf_pkg::VAR_W];
            end
            if (cmd.upd)
            begin
                est_reg <= est_next;
            end
        end
    end

    // Working registers (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            z_reg <= in_measurement;
        end
        if (cmd.den)
        begin
            pp_reg       <= pp_sat;
            den_reg      <= skf_pkg::DEN_W'(pp_sat) + skf_pkg::DEN_W'(r_reg);
            den_zero_reg <= (pp_sat == '0) && (r_reg == '0);
            rem_reg      <= skf_pkg::REM_W'(pp_sat);
            k_reg        <= '0;
            neg_reg      <= d_fwd[MAG_W-1];
            mag_reg      <= d_fwd[MAG_W-1] ? d_rev : d_fwd;
        end
        if (cmd.div_step)
        begin
            rem_reg <= {div_diff[skf_pkg::REM_W-2:0], 1'b0};
            k_reg   <= {k_reg[skf_pkg::GAIN_W-2:0], div_ge & ~den_zero_reg};
        end
        if (cmd.mul_var || cmd.mul_lo || cmd.mul_hi)
        begin
            mul_reg <= mul_a * mul_b;
        end
        if (cmd.mul_hi)
        begin
            lo_reg <= rounded[skf_pkg::FRAC_BITS +: skf_pkg::GAIN_W];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_est_reg <= est_reg;
            out_var_reg <= var_reg;
        end
    end

    assign status.out_free    = ~out_valid_reg | out_ready;
    assign out_valid          = out_valid_reg;
    assign out_estimate       = out_est_reg;
    assign out_error_variance = out_var_reg;

endmodule

// ----- hdl/scalar_kalman_filter_core.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_filter_core
// One-dimensional random-walk Kalman filter on signed Q16.16 samples.
// ----------------------------------------------------------------------------
// Usage:
//   sample_in carries one measurement per beat (valid/ready). result_out
//   returns one beat per sample: the filtered estimate (Q16.16) and the
//   updated error variance (unsigned Q8.24).
//   cfg_we/cfg_index/cfg_data write the process noise (index 0) and the
//   measurement noise (index 1); other indexes are ignored. Write only
//   while the core is idle.
// Sequence:
//   A sample is accepted in the idle state and the core takes no other
//   sample until its result is in the output register. Operand setup comes
//   first, then the 25-step radix-2 gain divider, the shared multiplier for
//   three products, the estimate update and the output hand-off. The next
//   sample can be taken in the same cycle that the result becomes valid.
// Reset:
//   Estimate 0, variance 1.0, noise registers at their defaults, no result.
// Stalls:
//   A finished result waits in the output register; if it is still held,
//   the next update completes its math and then waits for that beat.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_core #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [skf_pkg::VAR_W-1:0]      cfg_data,
    skf_in_if.sink                         sample_in,
    skf_out_if.source                      result_out
);

    skf_pkg::skf_cmd_t    cmd;
    skf_pkg::skf_status_t status;

    // Sequencer
    skf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_in.valid),
        .in_ready (sample_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and state
    skf_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_measurement     (sample_in.measurement),
        .cmd                (cmd),
        .status             (status),
        .out_valid          (result_out.valid),
        .out_ready          (result_out.ready),
        .out_estimate       (result_out.estimate),
        .out_error_variance (result_out.error_variance)
    );

endmodule

// ----- tb/tb_scalar_kalman_filter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scalar_kalman_filter_core
// Self-checking bench for the scalar Kalman filter core. A directed table hits
// the gain extremes (zero noise, zero denominator, saturated variance, full
// scale innovations, ignored register indexes), then random phases retune the
// noise registers and stream tracking-style samples with random stalls on both
// sides. Every result beat is checked against a bit-exact update model.
// ----------------------------------------------------------------------------
module tb_scalar_kalman_filter_core;

    localparam int W            = 32;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 40;      // margin beyond one full update
    localparam int LONG_HOLD    = 300;     // receiver back-pressure stretch
    localparam int STALL_LIMIT  = 2000;    // cycles with no beat before giving up
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 41;
    localparam int DIR_ROWS     = 20;

    // unused register slots, writes there must be dropped
    localparam logic [skf_pkg::CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [skf_pkg::CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic [W-1:0]              estimate;
        logic [skf_pkg::VAR_W-1:0] error_variance;
    } filter_out_t;

    typedef struct {
        row_kind_t                     kind;
        logic [skf_pkg::CFG_IDX_W-1:0] index;
        logic [31:0]                   value;     // sample or register data
        bit                            typed;     // expectation given in the row
        filter_out_t                   result;
    } stim_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [skf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [skf_pkg::VAR_W-1:0]     cfg_data;

    skf_in_if  #(.W(W)) sample_ch ();
    skf_out_if #(.W(W)) result_ch ();

    scalar_kalman_filter_core #(.SAMPLE_WIDTH(W)) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_ch),
        .result_out (result_ch)
    );

    // filter state mirrored by the bench
    longint                    track_est;
    logic [skf_pkg::VAR_W-1:0] track_var;
    logic [skf_pkg::VAR_W-1:0] proc_noise;
    logic [skf_pkg::VAR_W-1:0] meas_noise;

    filter_out_t pending_results[$];
    stim_row_t   directed_rows[DIR_ROWS];

    bit idle_on;
    bit hold_request;
    int samples_sent;
    int results_checked;
    int reg_writes;
    int mismatches;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // one filter update: predict, gain, correct, shrink the variance
    function automatic filter_out_t kalman_update(input logic signed [W-1:0] z);
        bit [63:0]   pp;
        bit [63:0]   den;
        bit [63:0]   gain;
        bit [63:0]   mag;
        bit [63:0]   corr;
        bit [63:0]   one;
        bit [63:0]   half;
        longint      innov;
        filter_out_t res;
        one  = 64'd1 << skf_pkg::FRAC_BITS;
        half = 64'd1 << (skf_pkg::FRAC_BITS - 1);
        pp = 64'(track_var) + 64'(proc_noise);
        if (pp > 64'hFFFF_FFFF)
            pp = 64'hFFFF_FFFF;
        den  = pp + 64'(meas_noise);
        gain = (den != 0) ? ((pp << skf_pkg::FRAC_BITS) / den) : 64'd0;
        if (gain > one)
            gain = one;
        innov = longint'(z) - track_est;
        mag   = (innov < 0) ? 64'(-innov) : 64'(innov);
        // correction rounded to nearest, ties away from zero
        corr  = gain * (mag >> skf_pkg::FRAC_BITS)
              + ((gain * (mag & (one - 1)) + half) >> skf_pkg::FRAC_BITS);
        track_est = (innov < 0) ? track_est - longint'(corr) : track_est + longint'(corr);
        track_var = skf_pkg::VAR_W'(((one - gain) * pp + half) >> skf_pkg::FRAC_BITS);
        res.estimate       = W'(track_est);
        res.error_variance = track_var;
        return res;
    endfunction

    // noise register value: extremes, defaults, and a spread of magnitudes
    function automatic logic [skf_pkg::VAR_W-1:0] pick_noise();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return '1;
            2:       return skf_pkg::RESET_PROCESS_NOISE;
            3:       return skf_pkg::RESET_MEASUREMENT_NOISE;
            4:       return $urandom;
            5:       return $urandom_range(0, 4096);
            default: return $urandom_range(0, 32'h0400_0000);
        endcase
    endfunction

    // mostly a noisy level around which the filter settles, some raw noise
    function automatic logic [W-1:0] pick_measurement(input longint level);
        longint m;
        case ($urandom_range(0, 9))
            0:       m = longint'($signed(32'($urandom)));
            1:       m = ($urandom_range(0, 1) != 0) ? 64'sd2147483647 : -64'sd2147483648;
            2, 3:    m = track_est + longint'($urandom_range(0, 32'h0020_0000)) - 64'sd1048576;
            default: m = level + longint'($urandom_range(0, 32'h0004_0000)) - 64'sd131072;
        endcase
        if (m > 64'sd2147483647)
            m = 64'sd2147483647;
        if (m < -64'sd2147483648)
            m = -64'sd2147483648;
        return W'(m);
    endfunction

    // offer one sample, optionally after a gap; expectation queued on accept
    task automatic send_sample(input logic [W-1:0] z, input bit typed,
                               input filter_out_t typed_res);
        filter_out_t res;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.measurement <= z;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        res = kalman_update(z);
        pending_results.insert(pending_results.size(), typed ? typed_res : res);
        samples_sent++;
    endtask

    // drop valid and let every outstanding result drain
    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // register write: cfg_we is pulsed and then dropped, so back-to-back writes never collide
    task automatic write_reg(input logic [skf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [skf_pkg::VAR_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == skf_pkg::CFG_PROCESS_NOISE)
            proc_noise = val;
        else if (idx == skf_pkg::CFG_MEASUREMENT_NOISE)
            meas_noise = val;
        reg_writes++;
        @(posedge clk);
    endtask

    // result receiver: random stalls, one long hold on request
    initial
    begin : result_sink
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        filter_out_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat est=%h var=%h", $time,
                         result_ch.estimate, result_ch.error_variance);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.estimate !== want.estimate)
                begin
                    $display("%0t: estimate mismatch: expected %h, got %h", $time,
                             want.estimate, result_ch.estimate);
                    mismatches++;
                end
                if (result_ch.error_variance !== want.error_variance)
                begin
                    $display("%0t: error_variance mismatch: expected %h, got %h", $time,
                             want.error_variance, result_ch.error_variance);
                    mismatches++;
                end
                results_checked++;
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat for %0d cycles, %0d results outstanding", $time,
                 STALL_LIMIT, pending_results.size());
        $display("** scalar_kalman_filter_core: FAILED **");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        longint level;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= '0;
        cfg_data              <= '0;
        sample_ch.valid       <= 1'b0;
        sample_ch.measurement <= '0;
        idle_on         = 1'b1;
        hold_request    = 1'b0;
        samples_sent    = 0;
        results_checked = 0;
        reg_writes      = 0;
        mismatches      = 0;
        track_est       = 0;
        track_var       = skf_pkg::RESET_VARIANCE;
        proc_noise      = skf_pkg::RESET_PROCESS_NOISE;
        meas_noise      = skf_pkg::RESET_MEASUREMENT_NOISE;

        // directed rows; with R = 0 the gain is one, so the estimate snaps to
        // the sample and the variance drops to zero
        directed_rows = '{
            '{ROW_SAMPLE, '0, 32'h0001_0000, 1'b0, '0},
            '{ROW_SAMPLE, '0, 32'hFFFF_0000, 1'b0, '0},
            '{ROW_CFG, skf_pkg::CFG_PROCESS_NOISE, 32'h0000_0000, 1'b0, '0},
            '{ROW_CFG, skf_pkg::CFG_MEASUREMENT_NOISE, 32'h0000_0000, 1'b0, '0},
            '{ROW_SAMPLE, '0, 32'h7FFF_FFFF, 1'b1, {32'h7FFF_FFFF, 32'h0}},
            // zero denominator: estimate held, variance stays zero
            '{ROW_SAMPLE, '0, 32'h8000_0000, 1'b1, {32'h7FFF_FFFF, 32'h0}},
            '{ROW_CFG, skf_pkg::CFG_PROCESS_NOISE, 32'hFFFF_FFFF, 1'b0, '0},
            // full-scale innovations in both directions at unity gain
            '{ROW_SAMPLE, '0, 32'h8000_0000, 1'b1, {32'h8000_0000, 32'h0}},
            '{ROW_SAMPLE, '0, 32'h7FFF_FFFF, 1'b1, {32'h7FFF_FFFF, 32'h0}},
            '{ROW_CFG, skf_pkg::CFG_MEASUREMENT_NOISE, 32'hFFFF_FFFF, 1'b0, '0},
            '{ROW_SAMPLE, '0, 32'h0000_0001, 1'b0, '0},
            // predicted variance saturates here
            '{ROW_SAMPLE, '0, 32'hFFFF_FFFF, 1'b0, '0},
            '{ROW_CFG, CFG_UNUSED_A, 32'h0000_0000, 1'b0, '0},
            '{ROW_CFG, CFG_UNUSED_B, 32'h1234_5678, 1'b0, '0},
            '{ROW_SAMPLE, '0, 32'h0000_0000, 1'b0, '0},
            '{ROW_CFG, skf_pkg::CFG_PROCESS_NOISE,
              skf_pkg::RESET_PROCESS_NOISE, 1'b0, '0},
            '{ROW_CFG, skf_pkg::CFG_MEASUREMENT_NOISE,
              skf_pkg::RESET_MEASUREMENT_NOISE, 1'b0, '0},
            '{ROW_SAMPLE, '0, 32'h0000_8000, 1'b0, '0},
            '{ROW_SAMPLE, '0, 32'h5555_5555, 1'b0, '0},
            '{ROW_SAMPLE, '0, 32'hAAAA_AAAA, 1'b0, '0}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(directed_rows[i].index, directed_rows[i].value);
            end
            else
                send_sample(directed_rows[i].value, directed_rows[i].typed,
                            directed_rows[i].result);
        end

        // random phases: retune noise, then track a noisy level
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph >= RAND_PHASES - 2)
                idle_on = 1'b0;
            wait_idle();
            write_reg(skf_pkg::CFG_PROCESS_NOISE, pick_noise());
            write_reg(skf_pkg::CFG_MEASUREMENT_NOISE, pick_noise());
            if ($urandom_range(0, 3) == 0)
                write_reg(($urandom_range(0, 1) != 0) ? CFG_UNUSED_A : CFG_UNUSED_B, $urandom);
            if (ph == 1)
                hold_request = 1'b1;
            level = longint'($signed(32'($urandom)));
            repeat (PHASE_ITEMS) send_sample(pick_measurement(level), 1'b0, '0);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d samples (%0d directed rows) over %0d noise phases, %0d register writes",
                 samples_sent, DIR_ROWS, RAND_PHASES, reg_writes);
        $display("Checked %0d result beats, %0d mismatches, %0d left unanswered",
                 results_checked, mismatches, pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0)
            $display("** scalar_kalman_filter_core: PASSED **");
        else
            $display("** scalar_kalman_filter_core: FAILED **");
        $finish;
    end

endmodule
